// ===== rtl/fxtanh_pkg.sv =====
`default_nettype none
package fxtanh_pkg;

	localparam int IN_W  = 32;
	localparam int OUT_W = 17;

	// saturation flags taken from the raw sample
	typedef struct packed {
		logic pos;
		logic neg;
	} sat_t;

	// control that travels with an item through the divider
	typedef struct packed {
		logic neg_q;
		sat_t sat;
	} flags_t;

endpackage
`default_nettype wire

// ===== rtl/fxtanh_poly.sv =====
`default_nettype none
module fxtanh_poly #(
	parameter int FRAC_BITS = 15
) (
	input  wire logic                                clk,
	input  wire logic [2:0]                          en,
	input  wire logic signed [fxtanh_pkg::IN_W-1:0]  x_in,
	output logic signed [FRAC_BITS+7:0]              num_s3,
	output logic [FRAC_BITS+6:0]                     den_s3,
	output fxtanh_pkg::sat_t                         sat_s3
);
	import fxtanh_pkg::*;

	localparam int XW  = FRAC_BITS + 3;
	localparam int X2W = FRAC_BITS + 4;
	localparam int SW  = FRAC_BITS + 7;
	localparam int NW  = FRAC_BITS + 8;
	localparam int DW  = FRAC_BITS + 7;

	localparam logic signed [IN_W-1:0] Three = IN_W'(3 * (1 << FRAC_BITS));
	localparam logic signed [IN_W-1:0] NegThree = -Three;
	localparam logic [DW-1:0] K27 = DW'(27 * (1 << FRAC_BITS));

	logic signed [XW-1:0]      x_s1;
	logic signed [XW-1:0]      x_s2;
	logic [X2W-1:0]            x2_s2;
	sat_t                      sat_s1;
	sat_t                      sat_s2;

	logic signed [2*XW-1:0]    sq;
	logic signed [2*XW-1:0]    sq_sh;
	logic [SW-1:0]             sum_u;
	logic signed [SW-1:0]      sum_sg;
	logic signed [XW+SW-1:0]   prod;
	logic signed [XW+SW-1:0]   prod_sh;
	logic [DW-1:0]             den_c;

	// saturated samples still run through, the flags override them at the end
	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1    <= x_in[XW-1:0];
			sat_s1.pos <= (x_in > Three);
			sat_s1.neg <= (x_in < NegThree);
		end
	end

	assign sq    = x_s1 * x_s1;
	assign sq_sh = sq >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s2   <= x_s1;
			x2_s2  <= sq_sh[X2W-1:0];
			sat_s2 <= sat_s1;
		end
	end

	assign sum_u   = K27 + {3'b000, x2_s2};
	assign sum_sg  = $signed(sum_u);
	assign prod    = x_s2 * sum_sg;
	assign prod_sh = prod >>> FRAC_BITS;
	// 9 * x^2 as shift and add
	assign den_c   = K27 + {x2_s2, 3'b000} + {3'b000, x2_s2};

	always_ff @(posedge clk) begin
		if (en[2]) begin
			num_s3 <= prod_sh[NW-1:0];
			den_s3 <= den_c;
			sat_s3 <= sat_s2;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/fxtanh_div_stage.sv =====
`default_nettype none
module fxtanh_div_stage #(
	parameter int FRAC_BITS = 15
) (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [FRAC_BITS+6:0]      rem_i,
	input  wire logic [FRAC_BITS+2:0]      acc_i,
	input  wire logic [FRAC_BITS+6:0]      den_i,
	input  wire fxtanh_pkg::flags_t        flags_i,
	output logic [FRAC_BITS+6:0]           rem_s,
	output logic [FRAC_BITS+2:0]           acc_s,
	output logic [FRAC_BITS+6:0]           den_s,
	output fxtanh_pkg::flags_t             flags_s
);
	import fxtanh_pkg::*;

	localparam int RW = FRAC_BITS + 7;
	localparam int QW = FRAC_BITS + 3;

	logic [RW:0]   trial;
	logic [RW:0]   diff;
	logic          qbit;

	// restoring step: bring down the next dividend bit, subtract if it fits
	assign trial = {rem_i, acc_i[QW-1]};
	assign diff  = trial - {1'b0, den_i};
	assign qbit  = (trial >= {1'b0, den_i});

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s   <= qbit ? diff[RW-1:0] : trial[RW-1:0];
			acc_s   <= {acc_i[QW-2:0], qbit};
			den_s   <= den_i;
			flags_s <= flags_i;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/fixed_point_tanh_pade.sv =====
`default_nettype none
// throughput: one sample per cycle while x_stall is low; three stages form the
// polynomial terms, then a restoring divider resolves one quotient bit per stage,
// then one output stage
// a stalled output holds its stage; empty stages further back keep filling
// reset clears only the stage valid bits; the datapath carries no reset
module fixed_point_tanh_pade #(
	parameter int FRAC_BITS = 15
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 x_valid,
	output logic                                      x_stall,
	input  wire logic signed [fxtanh_pkg::IN_W-1:0]   x_in,
	output logic                                      tanh_valid,
	input  wire logic                                 tanh_stall,
	output logic signed [fxtanh_pkg::OUT_W-1:0]       tanh_out
);
	import fxtanh_pkg::*;

	localparam int RW  = FRAC_BITS + 7;
	localparam int QW  = FRAC_BITS + 3;
	localparam int NW  = FRAC_BITS + 8;
	localparam int NST = QW + 4;
	localparam int QSW = (QW + 1 > OUT_W) ? QW + 1 : OUT_W;
	localparam logic [QSW-1:0] One = QSW'(1 << FRAC_BITS);

	logic [NST-1:0]             v_q;
	logic [NST:0]               rdy;

	logic signed [NW-1:0]       num_s3;
	logic [RW-1:0]              den_s3;
	sat_t                       sat_s3;

	logic [NW-1:0]              num_mag;
	logic [RW-1:0]              rem_d [QW+1];
	logic [QW-1:0]              acc_d [QW+1];
	logic [RW-1:0]              den_d [QW+1];
	flags_t                     flags_d [QW+1];

	logic [QSW-1:0]             quot_x;
	logic [QSW-1:0]             res;

	// a stage loads when it is empty or the stage after it moves on
	assign rdy[NST] = !tanh_stall;
	for (genvar k = 0; k < NST; k++) begin : g_rdy
		assign rdy[k] = !v_q[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= x_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign x_stall    = !rdy[0];
	assign tanh_valid = v_q[NST-1];

	fxtanh_poly #(
		.FRAC_BITS(FRAC_BITS)
	) u_poly (
		.clk    (clk),
		.en     (rdy[2:0]),
		.x_in   (x_in),
		.num_s3 (num_s3),
		.den_s3 (den_s3),
		.sat_s3 (sat_s3)
	);

	// divide |num| << FRAC_BITS by den; the upper dividend bits seed the remainder
	assign num_mag           = num_s3[NW-1] ? NW'(-num_s3) : NW'(num_s3);
	assign rem_d[0]          = {3'b000, num_mag[RW-1:3]};
	assign acc_d[0]          = {num_mag[2:0], {FRAC_BITS{1'b0}}};
	assign den_d[0]          = den_s3;
	assign flags_d[0].neg_q  = num_s3[NW-1];
	assign flags_d[0].sat    = sat_s3;

	for (genvar i = 0; i < QW; i++) begin : g_div
		fxtanh_div_stage #(
			.FRAC_BITS(FRAC_BITS)
		) u_stage (
			.clk     (clk),
			.en      (rdy[3+i]),
			.rem_i   (rem_d[i]),
			.acc_i   (acc_d[i]),
			.den_i   (den_d[i]),
			.flags_i (flags_d[i]),
			.rem_s   (rem_d[i+1]),
			.acc_s   (acc_d[i+1]),
			.den_s   (den_d[i+1]),
			.flags_s (flags_d[i+1])
		);
	end

	assign quot_x = {{(QSW-QW){1'b0}}, acc_d[QW]};

	always_comb begin
		if (flags_d[QW].sat.pos) begin
			res = One;
		end else if (flags_d[QW].sat.neg) begin
			res = -One;
		end else if (flags_d[QW].neg_q) begin
			res = -quot_x;
		end else begin
			res = quot_x;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NST-1]) begin
			tanh_out <= res[OUT_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== bench/fixed_point_tanh_pade_tb.sv =====
module fixed_point_tanh_pade_tb;

	import fxtanh_pkg::*;

	localparam int FRAC = 15;
	localparam int LATENCY = FRAC + 7;
	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD = 400;
	localparam longint ONE = longint'(1) << FRAC;
	localparam longint THREE = 3 * ONE;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic x_valid = 1'b0;
	logic signed [IN_W-1:0] x_in = '0;
	logic tanh_stall = 1'b0;
	logic x_stall;
	logic tanh_valid;
	logic signed [OUT_W-1:0] tanh_out;

	logic signed [OUT_W-1:0] expected_tanh[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int hold_request = 0;
	int rx_wait = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;

	fixed_point_tanh_pade dut (
		.clk(clk),
		.arst_n(arst_n),
		.x_valid(x_valid),
		.x_stall(x_stall),
		.x_in(x_in),
		.tanh_valid(tanh_valid),
		.tanh_stall(tanh_stall),
		.tanh_out(tanh_out)
	);

	always #5 clk = ~clk;

	// x(27 + x^2) / (27 + 9x^2) with floor shifts and a truncating divide
	function automatic logic signed [OUT_W-1:0] tanh_pade_q(input logic signed [IN_W-1:0] x);
		longint xs;
		longint sq;
		longint num;
		longint den;
		longint q;
		xs = x;
		if (xs > THREE) begin
			q = ONE;
		end else if (xs < -THREE) begin
			q = -ONE;
		end else begin
			sq = (xs * xs) >>> FRAC;
			num = (xs * (27 * ONE + sq)) >>> FRAC;
			den = 27 * ONE + ((9 * ONE * sq) >>> FRAC);
			q = (num * ONE) / den;
		end
		return q[OUT_W-1:0];
	endfunction

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, 15);
	endfunction

	task automatic report_mismatch(input string what, input logic signed [OUT_W-1:0] got,
			input logic signed [OUT_W-1:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// returns in the time step of the accepting edge
	task automatic send_sample(input logic signed [IN_W-1:0] x);
		int gap;
		gap = draw_gap(tx_burst);
		if (gap > 0) begin
			x_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		x_valid <= 1'b1;
		x_in <= x;
		do @(posedge clk); while (x_stall);
		expected_tanh.push_back(tanh_pade_q(x));
	endtask

	// receiver: per-result wait, or a long hold when a test asks for it
	always @(posedge clk) begin
		if (hold_request > 0) begin
			rx_wait = hold_request;
			hold_request = 0;
		end else if (tanh_valid && !tanh_stall) begin
			rx_wait = draw_gap(rx_burst);
		end else if (rx_wait > 0) begin
			rx_wait--;
		end
		tanh_stall <= (rx_wait > 0);
	end

	always @(posedge clk) begin
		logic signed [OUT_W-1:0] want;
		if (arst_n && tanh_valid && !tanh_stall) begin
			if (expected_tanh.size() == 0) begin
				report_mismatch("unexpected transaction tanh_out", tanh_out, '0);
			end else begin
				want = expected_tanh.pop_front();
				if (tanh_out !== want)
					report_mismatch("tanh_out", tanh_out, want);
			end
		end
	end

	always @(posedge clk) begin
		if ((x_valid && !x_stall) || (tanh_valid && !tanh_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic test_directed();
		logic signed [IN_W-1:0] corner[$];
		corner = '{0, 1, -1, 16384, -16384, 32767, 32768, -32768, 65536, -65536,
			98303, -98303, 98304, -98304, 98305, -98305, 200000, -200000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 32'h4000_0000, 32'hC000_0000,
			32'h5555_5555, 32'hAAAA_AAAA};
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		foreach (corner[i])
			send_sample(corner[i]);
	endtask

	task automatic test_random(input int count);
		logic signed [IN_W-1:0] x;
		int pick;
		for (int i = 0; i < count; i++) begin
			// change idling mode every few dozen transactions
			if (i % 40 == 0) begin
				tx_burst = ($urandom_range(0, 3) == 0);
				rx_burst = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 9);
			if (pick < 7)
				x = $urandom_range(0, 2 * THREE + 128) - (THREE + 64);
			else if (pick == 7)
				x = ($urandom_range(0, 1) ? THREE : -THREE) + $urandom_range(0, 16) - 8;
			else
				x = $urandom;
			send_sample(x);
		end
	endtask

	// receiver holds off while the sender streams, so the pipeline fills and stalls
	task automatic test_backpressure();
		tx_burst = 1'b1;
		rx_burst = 1'b0;
		hold_request = LONG_HOLD;
		for (int i = 0; i < 60; i++)
			send_sample($urandom_range(0, 2 * THREE) - THREE);
		tx_burst = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(420);
		test_backpressure();
		test_random(420);
		x_valid <= 1'b0;
		while (expected_tanh.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatches == 0 && expected_tanh.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
